[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assertion macros used by the checker
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define BFPD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define BFPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bfpd_pkg.sv]
// ---------------------------------------------------------------------------
// bfpd_pkg
// shared types, register indexes and helpers of the box filter downscaler
// ---------------------------------------------------------------------------
package bfpd_pkg;

  localparam int MAX_SRC_DEF = 512;
  localparam int MAX_DST_DEF = 64;
  localparam int PIX_W       = 8;
  localparam int PIX_MAX     = 255;
  localparam int NUM_CH      = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 10;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_SIZE   = 2'd2;

  // one classified source pixel on its way to the accumulators
  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha;
    logic [7:0]       col;
    logic             emit;
    logic             eor;
    logic             eoi;
  } item_t;

  // floor(x / 255), exact for x up to 255 * 255
  function automatic logic [PIX_W-1:0] div255(input logic [2*PIX_W-1:0] x);
    logic [2*PIX_W:0] s;
    s = {1'b0, x} + (2*PIX_W+1)'(x >> PIX_W) + (2*PIX_W+1)'(1);
    return s[2*PIX_W-1:PIX_W];
  endfunction

endpackage

[rtl/bfpd_div.sv]
// ---------------------------------------------------------------------------
// bfpd_div
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module bfpd_div #(
  parameter int NW = 16,
  parameter int DW = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);

  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   quo_q;
  logic [DW-1:0]   rem_q;
  logic [DW-1:0]   den_q;
  logic [CNTW-1:0] cnt_q;
  logic            done_q;
  logic [DW:0]     shifted;
  logic [DW:0]     diff;
  logic            ge;

  always_comb begin
    shifted = {rem_q, quo_q[NW-1]};
    ge      = shifted >= {1'b0, den_q};
    diff    = shifted - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNTW'(NW);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CNTW'(1);
      done_q <= (cnt_q == CNTW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[rtl/bfpd_front.sv]
// ---------------------------------------------------------------------------
// bfpd_front
// config registers, source position tracking and box boundary division
// ---------------------------------------------------------------------------
module bfpd_front #(
  parameter int MAX_SRC = 512,
  parameter int MAX_DST = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bfpd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bfpd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [bfpd_pkg::PIX_W-1:0]          red_i,
  input  logic [bfpd_pkg::PIX_W-1:0]          green_i,
  input  logic [bfpd_pkg::PIX_W-1:0]          blue_i,
  input  logic [bfpd_pkg::PIX_W-1:0]          alpha_i,
  input  logic                                full_i,
  output logic                                push_o,
  output bfpd_pkg::item_t                     push_item_o,
  output logic                                restart_o
);

  import bfpd_pkg::*;

  localparam int SW  = $clog2(MAX_SRC);
  localparam int LW  = SW + 1;
  localparam int DW  = (MAX_DST > 1) ? $clog2(MAX_DST) : 1;
  localparam int DCW = $clog2(MAX_DST + 1);
  localparam int NW  = $clog2(MAX_DST * MAX_SRC + 1);

  typedef enum logic [2:0] {
    S_INIT, S_COL0, S_ROW0, S_RUN, S_COL, S_ROW
  } state_e;

  state_e state_q;

  logic [CFG_DATA_W-1:0] src_width_q, src_height_q;
  logic [6:0]            dst_size_q;
  logic [SW-1:0]         src_col_q, src_row_q;
  logic [DW-1:0]         dst_col_q, dst_row_q;
  logic [LW-1:0]         col_end_q, row_end_q, col0_q, row0_q;
  logic                  restart_q;

  logic [LW-1:0]  w, h;
  logic [6:0]     d0;
  logic [DCW-1:0] d;
  logic           col_last, row_last, col_wrap, row_wrap;
  logic           need_col, need_row, eor, eoi;
  logic           accept, cfg_hit;
  logic           div_start, div_done;
  logic [NW-1:0]  div_num, div_quo, num_col, num_row;

  function automatic logic [LW-1:0] eff_dim(input logic [CFG_DATA_W-1:0] v);
    if (v == '0) return LW'(1);
    if (32'(v) > MAX_SRC) return LW'(MAX_SRC);
    return LW'(v);
  endfunction

  always_comb begin
    w  = eff_dim(src_width_q);
    h  = eff_dim(src_height_q);
    d0 = (dst_size_q == '0) ? 7'd1 : dst_size_q;
    d  = (32'(d0) > MAX_DST) ? DCW'(MAX_DST) : DCW'(d0);
    if (32'(d) > 32'(w)) d = DCW'(w);
    if (32'(d) > 32'(h)) d = DCW'(h);
  end

  always_comb begin
    col_last = ({1'b0, src_col_q} + LW'(1)) >= col_end_q;
    row_last = ({1'b0, src_row_q} + LW'(1)) >= row_end_q;
    col_wrap = ({1'b0, src_col_q} + LW'(1)) >= w;
    row_wrap = ({1'b0, src_row_q} + LW'(1)) >= h;
    need_col = col_last && !col_wrap;
    need_row = col_wrap && row_last && !row_wrap;
    eor      = (DCW'(dst_col_q) + DCW'(1)) >= d;
    eoi      = eor && ((DCW'(dst_row_q) + DCW'(1)) >= d);
    // end of the next box: (idx + 2) * len, divided by the side d
    num_col  = (NW'(dst_col_q) + NW'(2)) * NW'(w);
    num_row  = (NW'(dst_row_q) + NW'(2)) * NW'(h);
  end

  assign cfg_hit    = cfg_we_i && (cfg_idx_i == REG_SRC_WIDTH ||
                                   cfg_idx_i == REG_SRC_HEIGHT ||
                                   cfg_idx_i == REG_DST_SIZE);
  assign in_ready_o = (state_q == S_RUN) && !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    case (state_q)
      S_INIT: begin
        div_start = 1'b1;
        div_num   = NW'(w);
      end
      S_COL0: begin
        div_start = div_done;
        div_num   = NW'(h);
      end
      S_RUN: begin
        div_start = accept && (need_col || need_row);
        div_num   = need_col ? num_col : num_row;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  bfpd_div #(
    .NW(NW),
    .DW(DCW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (d),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      src_width_q  <= CFG_DATA_W'(1);
      src_height_q <= CFG_DATA_W'(1);
      dst_size_q   <= 7'd1;
      src_col_q    <= '0;
      src_row_q    <= '0;
      dst_col_q    <= '0;
      dst_row_q    <= '0;
      col_end_q    <= '0;
      row_end_q    <= '0;
      col0_q       <= '0;
      row0_q       <= '0;
      restart_q    <= 1'b0;
    end else begin
      restart_q <= cfg_hit;
      if (cfg_hit) begin
        case (cfg_idx_i)
          REG_SRC_WIDTH:  src_width_q  <= cfg_data_i;
          REG_SRC_HEIGHT: src_height_q <= cfg_data_i;
          default:        dst_size_q   <= cfg_data_i[6:0];
        endcase
        src_col_q <= '0;
        src_row_q <= '0;
        dst_col_q <= '0;
        dst_row_q <= '0;
        state_q   <= S_INIT;
      end else begin
        case (state_q)
          S_INIT: begin
            state_q <= S_COL0;
          end
          S_COL0: begin
            if (div_done) begin
              col0_q    <= LW'(div_quo);
              col_end_q <= LW'(div_quo);
              state_q   <= S_ROW0;
            end
          end
          S_ROW0: begin
            if (div_done) begin
              row0_q    <= LW'(div_quo);
              row_end_q <= LW'(div_quo);
              state_q   <= S_RUN;
            end
          end
          S_RUN: begin
            if (accept) begin
              if (col_wrap) begin
                src_col_q <= '0;
                dst_col_q <= '0;
                col_end_q <= col0_q;
                if (row_wrap) begin
                  src_row_q <= '0;
                  dst_row_q <= '0;
                  row_end_q <= row0_q;
                end else begin
                  src_row_q <= src_row_q + SW'(1);
                  if (row_last) begin
                    dst_row_q <= dst_row_q + DW'(1);
                    state_q   <= S_ROW;
                  end
                end
              end else begin
                src_col_q <= src_col_q + SW'(1);
                if (col_last) begin
                  dst_col_q <= dst_col_q + DW'(1);
                  state_q   <= S_COL;
                end
              end
            end
          end
          S_COL: begin
            if (div_done) begin
              col_end_q <= LW'(div_quo);
              state_q   <= S_RUN;
            end
          end
          S_ROW: begin
            if (div_done) begin
              row_end_q <= LW'(div_quo);
              state_q   <= S_RUN;
            end
          end
          default: begin
            state_q <= S_INIT;
          end
        endcase
      end
    end
  end

  always_comb begin
    push_item_o.red   = red_i;
    push_item_o.green = green_i;
    push_item_o.blue  = blue_i;
    push_item_o.alpha = alpha_i;
    push_item_o.col   = 8'(dst_col_q);
    push_item_o.emit  = col_last && row_last;
    push_item_o.eor   = eor;
    push_item_o.eoi   = eoi;
  end

  assign push_o    = accept;
  assign restart_o = restart_q;

endmodule

[rtl/bfpd_fifo.sv]
// ---------------------------------------------------------------------------
// bfpd_fifo
// two-entry queue of classified pixels between front and back
// ---------------------------------------------------------------------------
module bfpd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            flush_i,
  input  logic            push_i,
  input  bfpd_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output bfpd_pkg::item_t item_o
);

  import bfpd_pkg::*;

  item_t      slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign item_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else if (flush_i) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= item_i;
  end

endmodule

[rtl/bfpd_back.sv]
// ---------------------------------------------------------------------------
// bfpd_back
// per-column accumulators, box averages and premultiplied output register
// ---------------------------------------------------------------------------
module bfpd_back #(
  parameter int MAX_SRC = 512,
  parameter int MAX_DST = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       restart_i,
  input  logic                       empty_i,
  input  bfpd_pkg::item_t            item_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [bfpd_pkg::PIX_W-1:0] out_blue_o,
  output logic [bfpd_pkg::PIX_W-1:0] out_green_o,
  output logic [bfpd_pkg::PIX_W-1:0] out_red_o,
  output logic [bfpd_pkg::PIX_W-1:0] out_alpha_o,
  output logic                       end_of_row_o,
  output logic                       end_of_image_o
);

  import bfpd_pkg::*;

  localparam int DW   = (MAX_DST > 1) ? $clog2(MAX_DST) : 1;
  localparam int CW   = $clog2(longint'(MAX_SRC) * MAX_SRC + 1);
  localparam int SUMW = $clog2(longint'(MAX_SRC) * MAX_SRC * PIX_MAX + 1);

  typedef struct packed {
    logic [SUMW-1:0] r;
    logic [SUMW-1:0] g;
    logic [SUMW-1:0] b;
    logic [SUMW-1:0] a;
    logic [CW-1:0]   n;
  } acc_t;

  typedef enum logic [2:0] {
    B_IDLE, B_ACC, B_DIV, B_MUL, B_OUT
  } state_e;

  state_e             state_q;
  acc_t               mem_q [MAX_DST];
  logic [MAX_DST-1:0] valid_q;
  acc_t               rd_q;
  logic               rd_vld_q;
  item_t              cur_q;
  acc_t               acc_nxt;
  logic [DW-1:0]      rd_idx, cur_idx;

  logic [PIX_W-1:0]   avg_q  [NUM_CH];
  logic [2*PIX_W-1:0] prod_q [NUM_CH-1];
  logic [PIX_W-1:0]   alpha_q;

  logic               out_valid_q;
  logic [PIX_W-1:0]   out_b_q, out_g_q, out_r_q, out_a_q;
  logic               out_eor_q, out_eoi_q;
  logic               out_load;

  logic               div_start;
  logic [SUMW-1:0]    dnum  [NUM_CH];
  logic [SUMW-1:0]    dquo  [NUM_CH];
  logic [NUM_CH-1:0]  ddone;

  assign rd_idx   = item_i.col[DW-1:0];
  assign cur_idx  = cur_q.col[DW-1:0];
  assign pop_o    = (state_q == B_IDLE) && !empty_i;
  assign out_load = (state_q == B_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    acc_nxt   = rd_vld_q ? rd_q : '0;
    acc_nxt.r = acc_nxt.r + SUMW'(cur_q.red);
    acc_nxt.g = acc_nxt.g + SUMW'(cur_q.green);
    acc_nxt.b = acc_nxt.b + SUMW'(cur_q.blue);
    acc_nxt.a = acc_nxt.a + SUMW'(cur_q.alpha);
    acc_nxt.n = acc_nxt.n + CW'(1);
    dnum[0]   = acc_nxt.r;
    dnum[1]   = acc_nxt.g;
    dnum[2]   = acc_nxt.b;
    dnum[3]   = acc_nxt.a;
  end

  assign div_start = (state_q == B_ACC) && cur_q.emit;

  for (genvar gi = 0; gi < NUM_CH; gi++) begin : g_div
    bfpd_div #(
      .NW(SUMW),
      .DW(CW)
    ) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (div_start),
      .num_i   (dnum[gi]),
      .den_i   (acc_nxt.n),
      .done_o  (ddone[gi]),
      .quo_o   (dquo[gi])
    );
  end

  // accumulator memory: registered read at pop, write back after the add
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rd_q  <= mem_q[rd_idx];
      cur_q <= item_i;
    end
    if (state_q == B_ACC && !cur_q.emit) mem_q[cur_idx] <= acc_nxt;
  end

  // an entry without its valid bit reads as an empty box
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else if (restart_i) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (pop_o) rd_vld_q <= valid_q[rd_idx];
      if (state_q == B_ACC) valid_q[cur_idx] <= !cur_q.emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (pop_o) state_q <= B_ACC;
        end
        B_ACC: begin
          state_q <= cur_q.emit ? B_DIV : B_IDLE;
        end
        B_DIV: begin
          if (&ddone) begin
            for (int i = 0; i < NUM_CH; i++) avg_q[i] <= PIX_W'(dquo[i]);
            state_q <= B_MUL;
          end
        end
        B_MUL: begin
          for (int i = 0; i < NUM_CH - 1; i++) begin
            prod_q[i] <= (2*PIX_W)'(avg_q[i]) * (2*PIX_W)'(avg_q[3]);
          end
          alpha_q <= avg_q[3];
          state_q <= B_OUT;
        end
        B_OUT: begin
          if (out_load) begin
            out_r_q     <= div255(prod_q[0]);
            out_g_q     <= div255(prod_q[1]);
            out_b_q     <= div255(prod_q[2]);
            out_a_q     <= alpha_q;
            out_eor_q   <= cur_q.eor;
            out_eoi_q   <= cur_q.eoi;
            state_q     <= B_IDLE;
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_blue_o     = out_b_q;
  assign out_green_o    = out_g_q;
  assign out_red_o      = out_r_q;
  assign out_alpha_o    = out_a_q;
  assign end_of_row_o   = out_eor_q;
  assign end_of_image_o = out_eoi_q;

endmodule

[rtl/box_filter_premultiply_downscale.sv]
// path: a box-closing pixel passes the queue, accumulator read, four average dividers,
// premultiply register and output register; the front takes pixels while the queue has
// room, but a pixel that ends a box column or row short of the image edge holds it in the
// box-end divider; the back takes one pixel at a time, a box-closing one through its dividers
// reset: async active low; after reset or a register write the front finds the first box
// ends in its divider before it takes pixels; accumulators clear at once
// ---------------------------------------------------------------------------
// box_filter_premultiply_downscale
// box filter downscaler with premultiplied bgra output
// ---------------------------------------------------------------------------
module box_filter_premultiply_downscale #(
  parameter int MAX_SRC = bfpd_pkg::MAX_SRC_DEF,
  parameter int MAX_DST = bfpd_pkg::MAX_DST_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bfpd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bfpd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [bfpd_pkg::PIX_W-1:0]      red_i,
  input  logic [bfpd_pkg::PIX_W-1:0]      green_i,
  input  logic [bfpd_pkg::PIX_W-1:0]      blue_i,
  input  logic [bfpd_pkg::PIX_W-1:0]      alpha_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bfpd_pkg::PIX_W-1:0]      out_blue_o,
  output logic [bfpd_pkg::PIX_W-1:0]      out_green_o,
  output logic [bfpd_pkg::PIX_W-1:0]      out_red_o,
  output logic [bfpd_pkg::PIX_W-1:0]      out_alpha_o,
  output logic                            end_of_row_o,
  output logic                            end_of_image_o
);

  import bfpd_pkg::*;

  logic  push, full, pop, empty, restart;
  item_t push_item, pop_item;

  bfpd_front #(
    .MAX_SRC(MAX_SRC),
    .MAX_DST(MAX_DST)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .alpha_i     (alpha_i),
    .full_i      (full),
    .push_o      (push),
    .push_item_o (push_item),
    .restart_o   (restart)
  );

  bfpd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flush_i (restart),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (pop_item)
  );

  bfpd_back #(
    .MAX_SRC(MAX_SRC),
    .MAX_DST(MAX_DST)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .restart_i      (restart),
    .empty_i        (empty),
    .item_i         (pop_item),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_blue_o     (out_blue_o),
    .out_green_o    (out_green_o),
    .out_red_o      (out_red_o),
    .out_alpha_o    (out_alpha_o),
    .end_of_row_o   (end_of_row_o),
    .end_of_image_o (end_of_image_o)
  );

endmodule

[rtl/bfpd_checker.sv]
// ---------------------------------------------------------------------------
// bfpd_checker
// port-level checks of the box filter downscaler, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bfpd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_we_i,
  input logic [bfpd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [bfpd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic [bfpd_pkg::PIX_W-1:0]      red_i,
  input logic [bfpd_pkg::PIX_W-1:0]      green_i,
  input logic [bfpd_pkg::PIX_W-1:0]      blue_i,
  input logic [bfpd_pkg::PIX_W-1:0]      alpha_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [bfpd_pkg::PIX_W-1:0]      out_blue_o,
  input logic [bfpd_pkg::PIX_W-1:0]      out_green_o,
  input logic [bfpd_pkg::PIX_W-1:0]      out_red_o,
  input logic [bfpd_pkg::PIX_W-1:0]      out_alpha_o,
  input logic                            end_of_row_o,
  input logic                            end_of_image_o
);

  import bfpd_pkg::*;

  logic cfg_hit;
  assign cfg_hit = cfg_we_i && (cfg_idx_i == REG_SRC_WIDTH ||
                                cfg_idx_i == REG_SRC_HEIGHT ||
                                cfg_idx_i == REG_DST_SIZE);

  `BFPD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "output beat dropped")
  `BFPD_ASSERT_SAME(a_eoi_eor, out_valid_o && end_of_image_o, end_of_row_o, "image end off row end")
  `BFPD_ASSERT_SAME(a_red_le_a, out_valid_o, out_red_o <= out_alpha_o, "red above alpha")
  `BFPD_ASSERT_SAME(a_blue_le_a, out_valid_o, out_blue_o <= out_alpha_o, "blue above alpha")
  `BFPD_ASSERT_NEXT(a_cfg_stall, cfg_hit, !in_ready_o, "ready during restart")

endmodule

bind box_filter_premultiply_downscale bfpd_checker u_bfpd_checker (.*);

[dv/box_filter_premultiply_downscale_tb.sv]
// ---------------------------------------------------------------------------
// box_filter_premultiply_downscale_tb
// drives rgba source pixels under many size settings, predicts each premultiplied bgra
// beat or takes it from a directed table, and compares it with the output stream
// ---------------------------------------------------------------------------
module box_filter_premultiply_downscale_tb;
  import bfpd_pkg::*;

  localparam int          MAX_SRC    = 512;
  localparam int          MAX_DST    = 64;
  localparam int          CYCLE_LIMIT = 3000000;
  localparam int          DRAIN_WAIT = 100;
  localparam int          RAND_ITEMS = 1300;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic       eor;
    logic       eoi;
  } beat_t;

  typedef struct {
    logic [7:0] r, g, b, a;
    bit         typed;
    beat_t      want;
  } pixel_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [7:0]            red_i = '0, green_i = '0, blue_i = '0, alpha_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [7:0]            out_blue_o, out_green_o, out_red_o, out_alpha_o;
  logic                  end_of_row_o, end_of_image_o;

  box_filter_premultiply_downscale i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  int unsigned reg_w, reg_h, reg_d;
  int unsigned acc_r[MAX_DST], acc_g[MAX_DST], acc_b[MAX_DST], acc_a[MAX_DST];
  int unsigned acc_n[MAX_DST];
  int unsigned col, row, dcol, drow, col_end, row_end;

  beat_t pending_beats[$];
  int    failures = 0;
  int    beats_seen = 0;
  int    pixels_sent = 0;
  int    settings_used = 0;
  int    cycles = 0;

  function automatic int unsigned clamp_dim(int unsigned v);
    if (v == 0) return 1;
    if (v > MAX_SRC) return MAX_SRC;
    return v;
  endfunction

  function automatic int unsigned side();
    int unsigned d;
    d = (reg_d == 0) ? 1 : reg_d;
    if (d > MAX_DST) d = MAX_DST;
    if (d > clamp_dim(reg_w)) d = clamp_dim(reg_w);
    if (d > clamp_dim(reg_h)) d = clamp_dim(reg_h);
    return d;
  endfunction

  function automatic int unsigned box_limit(int unsigned idx, int unsigned len);
    return ((idx + 1) * len) / side();
  endfunction

  task automatic restart_image();
    for (int i = 0; i < MAX_DST; i++) begin
      acc_r[i] = 0; acc_g[i] = 0; acc_b[i] = 0; acc_a[i] = 0; acc_n[i] = 0;
    end
    col = 0; row = 0; dcol = 0; drow = 0;
    col_end = box_limit(0, clamp_dim(reg_w));
    row_end = box_limit(0, clamp_dim(reg_h));
  endtask

  // returns 1 and the averaged beat when the pixel closes a box
  function automatic bit accumulate_pixel(input logic [7:0] r, g, b, a, output beat_t bt);
    int unsigned w, h, d, c, k, ar, ag, ab, aa;
    bit          cl, rl, hit;
    w = clamp_dim(reg_w); h = clamp_dim(reg_h); d = side();
    c = (dcol >= MAX_DST) ? MAX_DST - 1 : (dcol & (MAX_DST - 1));
    hit = 1'b0;
    bt = '0;
    acc_r[c] += r; acc_g[c] += g; acc_b[c] += b; acc_a[c] += a; acc_n[c] += 1;
    cl = (col + 1) >= col_end;
    rl = (row + 1) >= row_end;
    if (cl && rl) begin
      k = acc_n[c] ? acc_n[c] : 1;
      ar = acc_r[c] / k; ag = acc_g[c] / k; ab = acc_b[c] / k; aa = acc_a[c] / k;
      bt.blue  = 8'(ab * aa / PIX_MAX);
      bt.green = 8'(ag * aa / PIX_MAX);
      bt.red   = 8'(ar * aa / PIX_MAX);
      bt.alpha = 8'(aa);
      bt.eor   = (dcol + 1) >= d;
      bt.eoi   = bt.eor && ((drow + 1) >= d);
      acc_r[c] = 0; acc_g[c] = 0; acc_b[c] = 0; acc_a[c] = 0; acc_n[c] = 0;
      hit = 1'b1;
    end
    col += 1;
    if (cl) begin
      dcol += 1;
      col_end = box_limit(dcol, w);
    end
    if (col >= w) begin
      col = 0; dcol = 0;
      col_end = box_limit(0, w);
      row += 1;
      if (rl) begin
        drow += 1;
        row_end = box_limit(drow, h);
      end
      if (row >= h) begin
        row = 0; drow = 0;
        row_end = box_limit(0, h);
      end
    end
    return hit;
  endfunction

  // called at a rising edge; leaves the port idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_SRC_WIDTH:  reg_w = val & 10'h3ff;
      REG_SRC_HEIGHT: reg_h = val & 10'h3ff;
      REG_DST_SIZE:   reg_d = val & 7'h7f;
      default: ;
    endcase
    if (idx != REG_SPARE) restart_image();
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic apply_sizes(input int unsigned w, h, d);
    wait_drained();
    write_reg(REG_SRC_WIDTH, w[9:0]);
    write_reg(REG_SRC_HEIGHT, h[9:0]);
    write_reg(REG_DST_SIZE, d[9:0]);
    if ($urandom_range(3) == 0) write_reg(REG_SPARE, 10'($urandom));
    settings_used++;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // entered at a rising edge, returns at the edge that accepted the beat
  task automatic send_pixel(input logic [7:0] r, g, b, a, input bit typed, input beat_t want);
    beat_t bt;
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_i <= r; green_i <= g; blue_i <= b; alpha_i <= a;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    pixels_sent++;
    if (accumulate_pixel(r, g, b, a, bt)) pending_beats.push_back(typed ? want : bt);
  endtask

  task automatic send_random();
    beat_t none;
    none = '0;
    send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, none);
  endtask

  // ready side: mostly ready, with short stalls, a few long ones and some open stretches
  int unsigned hold = 0;
  always @(posedge clk_i) begin
    if (hold != 0) begin
      hold <= hold - 1;
    end else begin
      case ($urandom_range(9))
        0, 1:    begin out_ready_i <= 1'b0; hold <= $urandom_range(1, 3); end
        2:       begin out_ready_i <= 1'b0; hold <= $urandom_range(10, 60); end
        3:       begin out_ready_i <= 1'b1; hold <= $urandom_range(20, 80); end
        default: out_ready_i <= 1'b1;
      endcase
    end
  end

  // outputs and ready are stable at the falling edge before the accepting edge
  always @(negedge clk_i) begin
    beat_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{out_blue_o, out_green_o, out_red_o, out_alpha_o, end_of_row_o, end_of_image_o};
      beats_seen++;
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %p", $time, got);
        failures++;
      end else begin
        want = pending_beats.pop_front();
        if (got.blue !== want.blue || got.green !== want.green || got.red !== want.red ||
            got.alpha !== want.alpha || got.eor !== want.eor || got.eoi !== want.eoi) begin
          $display("%0t: beat mismatch, expected %p, actual %p", $time, want, got);
          failures++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // at reset sizes every pixel is its own 1x1 box, so the beat is easy to read off
  pixel_row_t directed[] = '{
    '{8'd255, 8'd255, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1}},
    '{8'd0,   8'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 1'b1}},
    '{8'd255, 8'd128, 8'd1,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 1'b1}},
    '{8'd1,   8'd2,   8'd3,   8'd255, 1'b1, '{8'd3,   8'd2,   8'd1,   8'd255, 1'b1, 1'b1}},
    '{8'd0,   8'd0,   8'd0,   8'd255, 1'b1, '{8'd0,   8'd0,   8'd0,   8'd255, 1'b1, 1'b1}},
    '{8'd170, 8'd85,  8'd15,  8'd240, 1'b0, '0},
    '{8'd255, 8'd255, 8'd255, 8'd1,   1'b0, '0},
    '{8'd128, 8'd64,  8'd32,  8'd128, 1'b0, '0}
  };

  initial begin
    int unsigned w, h, d, n, stop_at;
    reg_w = 1; reg_h = 1; reg_d = 1;
    restart_image();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i])
      send_pixel(directed[i].r, directed[i].g, directed[i].b, directed[i].a,
                 directed[i].typed, directed[i].want);

    // special sizes: zero dims, oversize width, zero side, side above limit and dims
    apply_sizes(0, 0, 0);      repeat (3) send_random();
    apply_sizes(1023, 1, 1);   repeat (512) send_random();
    apply_sizes(4, 3, 127);    repeat (24) send_random();
    apply_sizes(70, 64, 127);  repeat (140) send_random();
    apply_sizes(7, 5, 3);      repeat (35) send_random();

    n = 0;
    while (n < RAND_ITEMS) begin
      case ($urandom_range(9))
        0:       begin w = $urandom; h = $urandom_range(0, 3); d = $urandom; end
        1:       begin w = $urandom_range(1, 4); h = $urandom_range(1, 4); d = $urandom; end
        default: begin
          w = $urandom_range(1, 24); h = $urandom_range(1, 24);
          d = $urandom_range(1, (w < h) ? w : h);
        end
      endcase
      apply_sizes(w, h, d);
      // mostly whole images, sometimes cut short by the next write
      stop_at = clamp_dim(w & 10'h3ff) * clamp_dim(h & 10'h3ff) * $urandom_range(1, 2);
      if (stop_at > 600) stop_at = 600;
      if ($urandom_range(4) == 0) stop_at = $urandom_range(1, stop_at);
      for (int i = 0; i < stop_at; i++) begin
        if (i == stop_at / 2 && $urandom_range(3) == 0) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          while (pending_beats.size() != 0) @(posedge clk_i);
        end
        send_random();
      end
      n += stop_at;
    end

    wait_drained();
    $display("sent %0d pixels over %0d size settings, %0d averaged beats checked",
             pixels_sent, settings_used, beats_seen);
    if (pending_beats.size() != 0) begin
      $display("%0t: %0d expected beats never arrived", $time, pending_beats.size());
      failures++;
    end
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
